>>> rtl/rvtrap_pkg.sv
// Shared types and constants for the RISC-V trap and interrupt unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rvtrap_pkg;

    // Operation selected by each input beat.
    typedef enum logic [1:0] {
        MODE_EXC   = 2'd0,
        MODE_POLL  = 2'd1,
        MODE_RAISE = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_EXC_DELEG  = 3'd0,
        CFG_INTR_DELEG = 3'd1,
        CFG_INTR_EN    = 3'd2,
        CFG_M_VEC      = 3'd3,
        CFG_S_VEC      = 3'd4
    } cfg_idx_t;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned XLEN = 64;
    localparam int unsigned IRQ_W = 12;
    localparam int unsigned NUM_IRQ_PRIO = 6;

    // Privilege levels.
    localparam logic [1:0] LVL_U = 2'd0;
    localparam logic [1:0] LVL_S = 2'd1;
    localparam logic [1:0] LVL_M = 2'd3;

    // The machine timer interrupt can never be delegated.
    localparam logic [IRQ_W-1:0] TIMER_M_MASK = 12'h080;

    // Interrupt codes from highest to lowest priority: MEI, MSI, MTI, SEI, SSI, STI.
    localparam logic [3:0] IRQ_ORDER [NUM_IRQ_PRIO] = '{4'd11, 4'd3, 4'd7, 4'd9, 4'd1, 4'd5};

    typedef struct packed {
        logic       spp;
        logic       spie;
        logic       sie;
        logic [1:0] mpp;
        logic       mpie;
        logic       mie;
    } status_t;

    typedef struct packed {
        logic [15:0]      exc_delegate;
        logic [IRQ_W-1:0] intr_delegate;
        logic [IRQ_W-1:0] intr_enable;
        logic [XLEN-1:0]  m_vector;
        logic [XLEN-1:0]  s_vector;
    } trap_cfg_t;

    typedef struct packed {
        logic [1:0]       current_level;
        status_t          status_bits;
        logic [XLEN-1:0]  machine_epc;
        logic [XLEN-1:0]  super_epc;
        logic [4:0]       machine_cause;
        logic [4:0]       super_cause;
        logic [XLEN-1:0]  machine_tval;
        logic [XLEN-1:0]  super_tval;
        logic [IRQ_W-1:0] pending_bits;
    } trap_state_t;

    typedef struct packed {
        mode_t            mode;
        logic [3:0]       cause;
        logic [XLEN-1:0]  trap_value;
        logic [XLEN-1:0]  current_pc;
        logic [IRQ_W-1:0] line_bits;
        logic             line_level;
    } trap_in_t;

    typedef struct packed {
        logic             trap_taken;
        logic [XLEN-1:0]  next_pc;
        logic [1:0]       new_level;
        logic [3:0]       taken_cause;
        logic             taken_is_interrupt;
        logic [IRQ_W-1:0] pending_now;
    } trap_out_t;

    // Result of a priority search over a set of interrupts.
    typedef struct packed {
        logic       hit;
        logic [3:0] code;
    } irq_pick_t;

endpackage

`default_nettype wire

>>> rtl/rvtrap_irq_sel.sv
// Fixed-priority selector over the standard interrupt codes.
// Depends on rvtrap_pkg.
`default_nettype none

module rvtrap_irq_sel (
    input  wire logic [rvtrap_pkg::IRQ_W-1:0] irq_set,
    output rvtrap_pkg::irq_pick_t             pick
);

    // Walk from lowest to highest priority so that the highest one present wins.
    always_comb begin
        pick = '0;
        for (int i = rvtrap_pkg::NUM_IRQ_PRIO - 1; i >= 0; i--) begin
            if (irq_set[rvtrap_pkg::IRQ_ORDER[i]]) begin
                pick.hit  = 1'b1;
                pick.code = rvtrap_pkg::IRQ_ORDER[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/rvtrap_core.sv
// Combinational trap logic: exception entry, interrupt poll, pending updates.
// Depends on rvtrap_pkg and rvtrap_irq_sel.
`default_nettype none

module rvtrap_core (
    input  wire rvtrap_pkg::trap_cfg_t   cfg,
    input  wire rvtrap_pkg::trap_state_t st,
    input  wire rvtrap_pkg::trap_in_t    item,
    output rvtrap_pkg::trap_state_t      st_next,
    output rvtrap_pkg::trap_out_t        result
);

    logic [1:0]                     lvl;
    logic                           below_m;
    logic [rvtrap_pkg::IRQ_W-1:0]   irq_deleg;
    logic [rvtrap_pkg::IRQ_W-1:0]   ready_set;
    logic                           m_on;
    logic                           s_on;
    rvtrap_pkg::irq_pick_t          m_pick;
    rvtrap_pkg::irq_pick_t          s_pick;
    logic                           m_wins;
    logic [rvtrap_pkg::IRQ_W-1:0]   line_set;
    logic                           take;
    logic                           to_super;
    logic                           is_irq;
    logic [3:0]                     code;
    logic [rvtrap_pkg::XLEN-1:0]    vec;
    logic [rvtrap_pkg::XLEN-1:0]    offset;
    logic [rvtrap_pkg::XLEN-1:0]    handler;

    assign lvl       = st.current_level;
    assign below_m   = (lvl != rvtrap_pkg::LVL_M);
    assign irq_deleg = cfg.intr_delegate & ~rvtrap_pkg::TIMER_M_MASK;
    assign ready_set = st.pending_bits & cfg.intr_enable;

    // Below machine level machine interrupts are always enabled; supervisor
    // interrupts are never taken at machine level.
    assign m_on = below_m || st.status_bits.mie;
    assign s_on = (lvl == rvtrap_pkg::LVL_U)
               || ((lvl == rvtrap_pkg::LVL_S) && st.status_bits.sie);

    rvtrap_irq_sel u_m_sel (
        .irq_set (ready_set & ~irq_deleg),
        .pick    (m_pick)
    );

    rvtrap_irq_sel u_s_sel (
        .irq_set (ready_set & irq_deleg),
        .pick    (s_pick)
    );

    assign m_wins   = m_on && m_pick.hit;
    assign line_set = item.line_level ? item.line_bits : (item.line_bits & cfg.intr_delegate);

    always_comb begin
        take     = 1'b0;
        to_super = 1'b0;
        is_irq   = 1'b0;
        code     = '0;
        st_next  = st;
        case (item.mode)
            rvtrap_pkg::MODE_EXC: begin
                take     = 1'b1;
                to_super = cfg.exc_delegate[item.cause] && below_m;
                code     = item.cause;
            end
            rvtrap_pkg::MODE_POLL: begin
                take     = m_wins || (s_on && s_pick.hit);
                to_super = !m_wins;
                is_irq   = 1'b1;
                code     = m_wins ? m_pick.code : s_pick.code;
            end
            rvtrap_pkg::MODE_RAISE: begin
                st_next.pending_bits = st.pending_bits | line_set;
            end
            rvtrap_pkg::MODE_CLEAR: begin
                st_next.pending_bits = st.pending_bits & ~line_set;
            end
            default: begin
                st_next = st;
            end
        endcase

        vec     = to_super ? cfg.s_vector : cfg.m_vector;
        offset  = (is_irq && vec[0]) ? {{(rvtrap_pkg::XLEN-6){1'b0}}, code, 2'b00} : '0;
        handler = {vec[rvtrap_pkg::XLEN-1:2], 2'b00} + offset;

        if (take) begin
            if (to_super) begin
                st_next.current_level    = rvtrap_pkg::LVL_S;
                st_next.super_epc        = item.current_pc;
                st_next.super_cause      = {is_irq, code};
                if (!is_irq) begin
                    st_next.super_tval = item.trap_value;
                end
                st_next.status_bits.spie = st.status_bits.sie;
                st_next.status_bits.sie  = 1'b0;
                st_next.status_bits.spp  = lvl[0];
            end else begin
                st_next.current_level    = rvtrap_pkg::LVL_M;
                st_next.machine_epc      = item.current_pc;
                st_next.machine_cause    = {is_irq, code};
                if (!is_irq) begin
                    st_next.machine_tval = item.trap_value;
                end
                st_next.status_bits.mpie = st.status_bits.mie;
                st_next.status_bits.mie  = 1'b0;
                st_next.status_bits.mpp  = lvl;
            end
        end
    end

    assign result.trap_taken         = take;
    assign result.next_pc            = take ? handler : '0;
    assign result.new_level          = st_next.current_level;
    assign result.taken_cause        = take ? code : '0;
    assign result.taken_is_interrupt = take && is_irq;
    assign result.pending_now        = st_next.pending_bits;

endmodule

`default_nettype wire

>>> rtl/riscv_trap_and_interrupt_unit.sv
// Top level of the RISC-V machine/supervisor trap and interrupt unit.
// Depends on rvtrap_pkg and rvtrap_core.
//
//   Channel   Ports                     Handshake        Beat
//   input     s_valid s_ready s_data    valid/ready      one trap_in_t
//   result    m_valid m_ready m_data    valid/ready      one trap_out_t
//   config    cfg_we cfg_index cfg_wdata  write enable   one register write
//
// Each beat passes through the input register and then the result register, and
// one beat is taken every cycle while the result is not stalled.
// The trap state is updated as a beat moves into the result register, so the
// following beat already sees it. aresetn is synchronous and active low and
// clears all state and configuration. A stalled result holds the input
// register, and s_ready drops only when both registers are full.
`default_nettype none

module riscv_trap_and_interrupt_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [rvtrap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rvtrap_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire rvtrap_pkg::trap_in_t              s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output rvtrap_pkg::trap_out_t                  m_data
);

    // The hart comes out of reset in machine mode with everything else cleared.
    localparam rvtrap_pkg::trap_state_t STATE_RESET =
        '{current_level: rvtrap_pkg::LVL_M, default: '0};

    rvtrap_pkg::trap_cfg_t   cfg_reg;
    rvtrap_pkg::trap_state_t state_reg;
    rvtrap_pkg::trap_state_t state_next;
    logic                    in_vld_reg;
    rvtrap_pkg::trap_in_t    in_data_reg;
    logic                    out_vld_reg;
    rvtrap_pkg::trap_out_t   out_data_reg;
    rvtrap_pkg::trap_out_t   result;
    logic                    advance;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                rvtrap_pkg::CFG_EXC_DELEG:  cfg_reg.exc_delegate  <= cfg_wdata[15:0];
                rvtrap_pkg::CFG_INTR_DELEG: cfg_reg.intr_delegate <= cfg_wdata[rvtrap_pkg::IRQ_W-1:0];
                rvtrap_pkg::CFG_INTR_EN:    cfg_reg.intr_enable   <= cfg_wdata[rvtrap_pkg::IRQ_W-1:0];
                rvtrap_pkg::CFG_M_VEC:      cfg_reg.m_vector      <= cfg_wdata;
                rvtrap_pkg::CFG_S_VEC:      cfg_reg.s_vector      <= cfg_wdata;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    rvtrap_core u_core (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .item    (in_data_reg),
        .st_next (state_next),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rvtrap_chk.sv
// Port-level checks for the trap and interrupt unit, bound to the top level.
// Depends on rvtrap_pkg and riscv_trap_and_interrupt_unit.
`default_nettype none

module rvtrap_chk (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire rvtrap_pkg::trap_out_t m_data
);

    // A result waiting for the sink must not change or vanish.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Nothing is offered in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // Without a trap the trap fields of the result are all zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.trap_taken |->
            m_data.next_pc == '0 && m_data.taken_cause == '0 && !m_data.taken_is_interrupt)
        else $error("trap fields set on a beat without a trap");

    // A trap always lands in S or M mode at a word-aligned handler.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.trap_taken |->
            m_data.next_pc[1:0] == 2'b00
            && (m_data.new_level == rvtrap_pkg::LVL_S || m_data.new_level == rvtrap_pkg::LVL_M))
        else $error("trap entered with bad level or misaligned handler");

    // A taken interrupt straight after a trap that left the hart at machine level
    // cannot go to supervisor level.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.trap_taken && m_data.new_level == rvtrap_pkg::LVL_M
        ##1 m_valid && m_data.trap_taken && m_data.taken_is_interrupt
        |-> m_data.new_level == rvtrap_pkg::LVL_M)
        else $error("interrupt delegated while running in machine mode");

endmodule

bind riscv_trap_and_interrupt_unit rvtrap_chk u_rvtrap_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
